// ----- rtl/core/dsos_pkg.sv -----
// dsos_pkg: shared constants and the saturation helper for the damped spring offset block
// used by dsos_iter, damped_spring_offset_step_top and the test benches; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package dsos_pkg;

    // fixed point format and reset values
    localparam int DSOS_FRAC_BITS   = 16;
    localparam int DSOS_STEP_BITS   = 16;
    localparam int DSOS_SPRING_INT  = 5000;
    localparam int DSOS_DAMP_INT    = 10;
    localparam logic [15:0] DSOS_MAX_STEP_RST = 16'd1311;

    // item commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_KICK  = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;

    // iterative unit modes
    localparam logic MODE_SQRT = 1'b0;
    localparam logic MODE_DIV  = 1'b1;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // clamp a wide signed value to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = S32_MAX;
        end else if (v < -66'sd2147483648) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dsos_mul.sv -----
// dsos_mul: shared 33x33 signed multiplier with a registered product
// depends on nothing beyond the clock
`timescale 1ns / 1ps
`default_nettype none

module dsos_mul (
    input  wire logic               i_clk,
    input  wire logic signed [32:0] i_a,
    input  wire logic signed [32:0] i_b,
    output logic signed [65:0]      o_p
);

    logic signed [65:0] r_p;

    // product register, valid the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ----- rtl/core/dsos_iter.sv -----
// dsos_iter: shared shift-subtract unit for square root (2 bits a cycle)
// and signed 64 by unsigned 32 bit truncating division (1 bit a cycle); uses dsos_pkg
`timescale 1ns / 1ps
`default_nettype none

module dsos_iter
    import dsos_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_mode,
    input  wire logic [63:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_res
);

    logic [63:0] r_sh;
    logic [35:0] r_rem;
    logic [31:0] r_root;
    logic [31:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_mode;
    logic        r_neg;
    logic        r_busy;
    logic        r_done;

    logic [35:0] part;
    logic [35:0] cand;
    logic [35:0] diff;
    logic        ge;
    logic [63:0] mag;
    logic [63:0] num_abs;

    // shared partial remainder compare and subtract
    always_comb begin
        if (r_mode == MODE_SQRT) begin
            part = {r_rem[33:0], r_sh[63:62]};
            cand = {2'b00, r_root, 2'b01};
        end else begin
            part = {r_rem[34:0], r_sh[63]};
            cand = {4'b0000, r_den};
        end
        ge   = (part >= cand);
        diff = part - cand;
    end

    assign num_abs = (i_mode == MODE_DIV && i_num[63]) ? (64'd0 - i_num) : i_num;

    // sequencer of the digit steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_mode <= i_mode;
                r_neg  <= (i_mode == MODE_DIV) && i_num[63];
                r_sh   <= num_abs;
                r_den  <= i_den;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= (i_mode == MODE_SQRT) ? 7'd32 : 7'd64;
            end else if (r_busy) begin
                r_rem <= ge ? diff : part;
                if (r_mode == MODE_SQRT) begin
                    r_root <= {r_root[30:0], ge};
                    r_sh   <= {r_sh[61:0], 2'b00};
                end else begin
                    r_sh <= {r_sh[62:0], ge};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // result: root, or signed quotient clamped to 32 bits
    assign mag = r_sh;
    always_comb begin
        if (r_mode == MODE_SQRT) begin
            o_res = r_root;
        end else if (r_neg) begin
            o_res = (mag > 64'h0000_0000_8000_0000) ? S32_MIN : (32'd0 - mag[31:0]);
        end else begin
            o_res = (mag > 64'h0000_0000_7FFF_FFFF) ? S32_MAX : mag[31:0];
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

// ----- rtl/core/damped_spring_offset_step_top.sv -----
// kick, reset, paused tick or unused command: from the idle state to the output state,
// which loads the result register once it is empty or being read
// tick: a 32-step square root, then three 64-step divisions (skipped at zero position)
// in the shared iterative unit, and sequencer states around the shared multiplier
// throughput: one item at a time, input ready only while the sequencer is idle,
// which starts at the same edge that loads the result register
// reset: synchronous active low, clears state to zero and gains to their defaults
// damped_spring_offset_step_top: sequencer, state and stream ports; uses dsos_pkg,
// dsos_mul and dsos_iter
`timescale 1ns / 1ps
`default_nettype none

module damped_spring_offset_step_top
    import dsos_pkg::*;
#(
    parameter int FRAC_BITS = DSOS_FRAC_BITS
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [15:0]  i_cfg_wdata,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // step_time[15:0], kick_x[47:16], kick_y[79:48], kick_spring[111:80], kick_damp[143:112]
    input  wire logic [143:0] i_s_axis_tdata,
    // command[1:0], paused[2]
    input  wire logic [2:0]   i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // offset_x[31:0], offset_y[63:32]
    output logic [63:0]       o_m_axis_tdata
);

    localparam logic [63:0] SPRING_WIDE = 64'(DSOS_SPRING_INT) << FRAC_BITS;
    localparam logic [63:0] DAMP_WIDE   = 64'(DSOS_DAMP_INT) << FRAC_BITS;
    localparam logic [31:0] SPRING_RST  =
        (SPRING_WIDE > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : SPRING_WIDE[31:0];
    localparam logic [31:0] DAMP_RST    =
        (DAMP_WIDE > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : DAMP_WIDE[31:0];

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_M_PXX   = 5'd1;
    localparam logic [4:0] ST_M_PYY   = 5'd2;
    localparam logic [4:0] ST_SQ_GO   = 5'd3;
    localparam logic [4:0] ST_SQ_WAIT = 5'd4;
    localparam logic [4:0] ST_M_H     = 5'd5;
    localparam logic [4:0] ST_M_PVX   = 5'd6;
    localparam logic [4:0] ST_M_PVY   = 5'd7;
    localparam logic [4:0] ST_PROJ    = 5'd8;
    localparam logic [4:0] ST_M_D     = 5'd9;
    localparam logic [4:0] ST_D_GO    = 5'd10;
    localparam logic [4:0] ST_D_WAIT  = 5'd11;
    localparam logic [4:0] ST_M_SUM   = 5'd12;
    localparam logic [4:0] ST_M_MX    = 5'd13;
    localparam logic [4:0] ST_FX_GO   = 5'd14;
    localparam logic [4:0] ST_FX_WAIT = 5'd15;
    localparam logic [4:0] ST_M_MY    = 5'd16;
    localparam logic [4:0] ST_FY_GO   = 5'd17;
    localparam logic [4:0] ST_FY_WAIT = 5'd18;
    localparam logic [4:0] ST_M_V1    = 5'd19;
    localparam logic [4:0] ST_M_V2    = 5'd20;
    localparam logic [4:0] ST_M_P1    = 5'd21;
    localparam logic [4:0] ST_M_P2    = 5'd22;
    localparam logic [4:0] ST_M_P3    = 5'd23;
    localparam logic [4:0] ST_OUT     = 5'd24;

    logic [4:0]         r_state, n_state;
    logic [15:0]        r_max_step;
    logic signed [31:0] r_px, r_py, r_vx, r_vy;
    logic [31:0]        r_ks, r_kd;
    logic [15:0]        r_step;
    logic [63:0]        r_acc;
    logic [31:0]        r_len;
    logic signed [31:0] r_h, r_proj, r_d, r_m, r_fx, r_fy;
    logic               r_mvalid;
    logic [63:0]        r_mdata;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic signed [65:0] prod_f;
    logic signed [65:0] prod_s;
    logic [65:0]        prod_h;
    logic               it_start, it_mode, it_done;
    logic [63:0]        it_num;
    logic [31:0]        it_res;

    logic               s_acc;
    logic [1:0]         in_cmd;
    logic               in_paused;
    logic [15:0]        in_step;

    assign in_cmd    = i_s_axis_tuser[1:0];
    assign in_paused = i_s_axis_tuser[2];
    assign in_step   = i_s_axis_tdata[15:0];
    assign s_acc     = i_s_axis_tvalid && o_s_axis_tready;

    dsos_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    dsos_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (it_start),
        .i_mode  (it_mode),
        .i_num   (it_num),
        .i_den   (r_len),
        .o_done  (it_done),
        .o_res   (it_res)
    );

    // product views: fraction shift, step shift, unsigned gain shift
    assign prod_f = prod >>> FRAC_BITS;
    assign prod_s = prod >>> DSOS_STEP_BITS;
    assign prod_h = $unsigned(prod) >> FRAC_BITS;

    // multiplier operand select per sequencer state
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_M_PXX: begin mul_a = 33'(r_px); mul_b = 33'(r_px); end
            ST_M_PYY: begin mul_a = 33'(r_py); mul_b = 33'(r_py); end
            ST_M_H:   begin mul_a = {1'b0, r_len}; mul_b = {1'b0, r_ks}; end
            ST_M_PVX: begin mul_a = 33'(r_px); mul_b = 33'(r_vx); end
            ST_M_PVY: begin mul_a = 33'(r_py); mul_b = 33'(r_vy); end
            ST_M_D:   begin mul_a = 33'(r_proj); mul_b = {1'b0, r_kd}; end
            ST_M_MX:  begin mul_a = 33'(r_m); mul_b = 33'(r_px); end
            ST_M_MY:  begin mul_a = 33'(r_m); mul_b = 33'(r_py); end
            ST_M_V1:  begin mul_a = {17'd0, r_step}; mul_b = 33'(r_fx); end
            ST_M_V2:  begin mul_a = {17'd0, r_step}; mul_b = 33'(r_fy); end
            ST_M_P1:  begin mul_a = {17'd0, r_step}; mul_b = 33'(r_vx); end
            ST_M_P2:  begin mul_a = {17'd0, r_step}; mul_b = 33'(r_vy); end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // iterative unit start and operand
    always_comb begin
        it_start = 1'b0;
        it_mode  = MODE_DIV;
        it_num   = prod[63:0];
        case (r_state)
            ST_SQ_GO: begin
                it_start = 1'b1;
                it_mode  = MODE_SQRT;
                it_num   = r_acc + prod[63:0];
            end
            ST_D_GO: begin
                it_start = 1'b1;
            end
            ST_FX_GO, ST_FY_GO: begin
                it_start = 1'b1;
                it_num   = 64'd0 - prod[63:0];
            end
            default: begin
                it_start = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_state = (in_cmd == CMD_TICK && !in_paused) ? ST_M_PXX : ST_OUT;
                end
            end
            ST_M_PXX:   n_state = ST_M_PYY;
            ST_M_PYY:   n_state = ST_SQ_GO;
            ST_SQ_GO:   n_state = ST_SQ_WAIT;
            ST_SQ_WAIT: begin
                if (it_done) begin
                    n_state = (it_res == 32'd0) ? ST_M_V1 : ST_M_H;
                end
            end
            ST_M_H:     n_state = ST_M_PVX;
            ST_M_PVX:   n_state = ST_M_PVY;
            ST_M_PVY:   n_state = ST_PROJ;
            ST_PROJ:    n_state = ST_M_D;
            ST_M_D:     n_state = ST_D_GO;
            ST_D_GO:    n_state = ST_D_WAIT;
            ST_D_WAIT:  n_state = it_done ? ST_M_SUM : ST_D_WAIT;
            ST_M_SUM:   n_state = ST_M_MX;
            ST_M_MX:    n_state = ST_FX_GO;
            ST_FX_GO:   n_state = ST_FX_WAIT;
            ST_FX_WAIT: n_state = it_done ? ST_M_MY : ST_FX_WAIT;
            ST_M_MY:    n_state = ST_FY_GO;
            ST_FY_GO:   n_state = ST_FY_WAIT;
            ST_FY_WAIT: n_state = it_done ? ST_M_V1 : ST_FY_WAIT;
            ST_M_V1:    n_state = ST_M_V2;
            ST_M_V2:    n_state = ST_M_P1;
            ST_M_P1:    n_state = ST_M_P2;
            ST_M_P2:    n_state = ST_M_P3;
            ST_M_P3:    n_state = ST_OUT;
            ST_OUT: begin
                if (!r_mvalid || i_m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // control, configuration and spring state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_max_step <= DSOS_MAX_STEP_RST;
            r_px       <= '0;
            r_py       <= '0;
            r_vx       <= '0;
            r_vy       <= '0;
            r_ks       <= SPRING_RST;
            r_kd       <= DAMP_RST;
            r_mvalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_max_step <= i_cfg_wdata;
            end
            // command handling at the input transaction
            if (r_state == ST_IDLE && s_acc) begin
                r_step <= (in_step <= r_max_step) ? in_step : r_max_step;
                case (in_cmd)
                    CMD_KICK: begin
                        r_px <= i_s_axis_tdata[47:16];
                        r_py <= i_s_axis_tdata[79:48];
                        r_vx <= '0;
                        r_vy <= '0;
                        r_ks <= i_s_axis_tdata[111:80];
                        r_kd <= i_s_axis_tdata[143:112];
                    end
                    CMD_RESET: begin
                        r_px <= '0;
                        r_py <= '0;
                        r_vx <= '0;
                        r_vy <= '0;
                    end
                    default: ;
                endcase
            end
            // semi-implicit euler update, velocity first
            case (r_state)
                ST_M_V2: r_vx <= sat32(66'(r_vx) + prod_s);
                ST_M_P1: r_vy <= sat32(66'(r_vy) + prod_s);
                ST_M_P2: r_px <= sat32(66'(r_px) + prod_s);
                ST_M_P3: r_py <= sat32(66'(r_py) + prod_s);
                default: ;
            endcase
            // result register toward the master side
            if (r_state == ST_OUT && (!r_mvalid || i_m_axis_tready)) begin
                r_mvalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    // force datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_M_PYY:   r_acc <= prod[63:0];
            ST_M_PVY:   r_acc <= prod_f[63:0];
            default:    r_acc <= r_acc;
        endcase
        if (r_state == ST_SQ_WAIT && it_done) begin
            r_len <= it_res;
            r_fx  <= '0;
            r_fy  <= '0;
        end
        if (r_state == ST_M_PVX) begin
            r_h <= (|prod_h[65:31]) ? S32_MAX : prod_h[31:0];
        end
        if (r_state == ST_PROJ) begin
            r_proj <= sat32(66'($signed(r_acc)) + prod_f);
        end
        if (r_state == ST_D_WAIT && it_done) begin
            r_d <= it_res;
        end
        if (r_state == ST_M_SUM) begin
            r_m <= sat32(66'(r_h) + 66'(r_d));
        end
        if (r_state == ST_FX_WAIT && it_done) begin
            r_fx <= it_res;
        end
        if (r_state == ST_FY_WAIT && it_done) begin
            r_fy <= it_res;
        end
        if (r_state == ST_OUT && (!r_mvalid || i_m_axis_tready)) begin
            r_mdata <= {r_py, r_px};
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_mvalid;
    assign o_m_axis_tdata  = r_mdata;

endmodule

`default_nettype wire

// ----- rtl/core/dsos_checker.sv -----
// dsos_checker: port level checks of the damped spring offset top level
// bound to damped_spring_offset_step_top; depends on nothing else
`timescale 1ns / 1ps
`default_nettype none

module dsos_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        o_s_axis_tready,
    input  wire logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [63:0] o_m_axis_tdata
);

    // a result held back stays valid
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result valid dropped while stalled");

    // a result held back keeps its data
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result data changed while stalled");

    // one transaction at a time: busy right after an input transaction
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted while busy");

    // reset empties the result register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind damped_spring_offset_step_top dsos_checker u_dsos_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

// ----- test/damped_spring_offset_step_checker.sv -----
// damped_spring_offset_step_checker: watches the stream channels and config port, predicts
// each offset with a fixed point spring model and compares; depends on dsos_pkg
`timescale 1ns / 1ps
`default_nettype none

module damped_spring_offset_step_checker
    import dsos_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [15:0]  i_cfg_wdata,
    input  wire logic         i_s_tvalid,
    input  wire logic         i_s_tready,
    input  wire logic [143:0] i_s_tdata,
    input  wire logic [2:0]   i_s_tuser,
    input  wire logic         i_m_tvalid,
    input  wire logic         i_m_tready,
    input  wire logic [63:0]  i_m_tdata,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic signed [31:0] off_y;
        logic signed [31:0] off_x;
    } t_offset;

    localparam int FRAC_BITS_C = DSOS_FRAC_BITS;

    // model state
    logic [15:0]        step_cap;
    logic signed [31:0] px_q, py_q, vx_q, vy_q;
    logic [31:0]        ks_q, kd_q;
    t_offset            offset_fifo[$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // bitwise integer square root of a 64 bit value
    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // one semi-implicit euler step of the damped spring
    task automatic spring_step(input logic [15:0] dt_in);
        longint px, py, vx, vy, stp, fx, fy, lenl, h, proj, d, m;
        logic [63:0] sq, len, hraw;
        px = px_q; py = py_q; vx = vx_q; vy = vy_q;
        stp = (dt_in <= step_cap) ? longint'(dt_in) : longint'(step_cap);
        sq = 64'(px * px) + 64'(py * py);
        len = root64(sq);
        fx = 0; fy = 0;
        if (len != 0) begin
            lenl = longint'(len);
            hraw = (len * {32'd0, ks_q}) >> FRAC_BITS_C;
            h = (hraw > 64'd2147483647) ? 64'sd2147483647 : longint'(hraw);
            proj = clamp32(((px * vx) >>> FRAC_BITS_C) + ((py * vy) >>> FRAC_BITS_C));
            d = clamp32((proj * longint'({32'd0, kd_q})) / lenl);
            m = clamp32(h + d);
            fx = clamp32(-(m * px) / lenl);
            fy = clamp32(-(m * py) / lenl);
        end
        vx = clamp32(vx + ((stp * fx) >>> 16));
        vy = clamp32(vy + ((stp * fy) >>> 16));
        px = clamp32(px + ((stp * vx) >>> 16));
        py = clamp32(py + ((stp * vy) >>> 16));
        vx_q = vx[31:0]; vy_q = vy[31:0];
        px_q = px[31:0]; py_q = py[31:0];
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    assign o_pending = offset_fifo.size();

    // predict on each accepted item, compare each accepted result
    always @(posedge i_clk) begin
        t_offset got, want;
        if (!i_rst_n) begin
            step_cap = DSOS_MAX_STEP_RST;
            px_q = 0; py_q = 0; vx_q = 0; vy_q = 0;
            ks_q = 32'(DSOS_SPRING_INT) << DSOS_FRAC_BITS;
            kd_q = 32'(DSOS_DAMP_INT) << DSOS_FRAC_BITS;
            offset_fifo.delete();
        end else begin
            if (i_cfg_we) step_cap = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) begin
                case (i_s_tuser[1:0])
                    CMD_TICK: if (!i_s_tuser[2]) spring_step(i_s_tdata[15:0]);
                    CMD_KICK: begin
                        px_q = i_s_tdata[47:16];
                        py_q = i_s_tdata[79:48];
                        vx_q = 0; vy_q = 0;
                        ks_q = i_s_tdata[111:80];
                        kd_q = i_s_tdata[143:112];
                    end
                    CMD_RESET: begin
                        px_q = 0; py_q = 0; vx_q = 0; vy_q = 0;
                    end
                    default: ;
                endcase
                offset_fifo.push_back('{off_y: py_q, off_x: px_q});
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (offset_fifo.size() == 0) begin
                    $display("unexpected result %h at %0t", i_m_tdata, $realtime);
                    o_fail_count++;
                end else begin
                    want = offset_fifo.pop_front();
                    if (got.off_x !== want.off_x) report_mismatch("offset_x", got.off_x, want.off_x);
                    if (got.off_y !== want.off_y) report_mismatch("offset_y", got.off_y, want.off_y);
                end
            end
        end
    end

    initial o_fail_count = 0;

endmodule

`default_nettype wire

// ----- test/damped_spring_offset_step_top_test.sv -----
// damped_spring_offset_step_top_test: clock, reset, stimulus phases and verdict
// depends on dsos_pkg, damped_spring_offset_step_top and damped_spring_offset_step_checker
`timescale 1ns / 1ps
`default_nettype none

module damped_spring_offset_step_top_test;
    import dsos_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 40000;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_we = 0;
    logic [15:0]  i_cfg_wdata = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [143:0] s_tdata = 0;   // step_time, kick_x, kick_y, kick_spring, kick_damp
    logic [2:0]   s_tuser = 0;   // command, paused
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [63:0]  m_tdata;       // offset_x, offset_y
    int           fail_count;
    int           pending;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           quiet_cycles = 0;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    damped_spring_offset_step_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata)
    );

    damped_spring_offset_step_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stalls
    always @(negedge i_clk) m_tready <= ($urandom_range(99) >= stall_pct);

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // present one item, return at the falling edge after it is taken
    task automatic send_item(input logic [1:0] cmd, input logic [15:0] dt, input logic pause,
                             input logic [31:0] kx, input logic [31:0] ky,
                             input logic [31:0] ks, input logic [31:0] kd);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid = 0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_tdata = {kd, ks, ky, kx, dt};
        s_tuser = {pause, cmd};
        s_tvalid = 1;
        forever begin
            @(posedge i_clk);
            if (s_tready) break;
        end
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_mag();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(3))
            0: v = 32'($signed(v) >>> $urandom_range(31));
            1: v = 32'($signed(v) >>> 12);
            default: v = 32'($signed(v) >>> 4);
        endcase
        return v;
    endfunction

    task automatic random_item();
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            send_item(CMD_TICK, ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(3000)),
                      $urandom_range(19) == 0, $urandom(), $urandom(), $urandom(), $urandom());
        end else if (r < 90) begin
            send_item(CMD_KICK, 16'($urandom()), 1'($urandom_range(1)), rand_mag(), rand_mag(),
                      ($urandom_range(3) == 0) ? $urandom() : $urandom() >> $urandom_range(31),
                      ($urandom_range(3) == 0) ? $urandom() : $urandom() >> $urandom_range(31));
        end else if (r < 96) begin
            send_item(CMD_RESET, 16'($urandom()), 1'($urandom_range(1)), $urandom(), $urandom(),
                      $urandom(), $urandom());
        end else begin
            send_item(CMD_UNUSED, 16'($urandom()), 1'($urandom_range(1)), $urandom(), $urandom(),
                      $urandom(), $urandom());
        end
    endtask

    task automatic write_step_cap(input logic [15:0] v);
        s_tvalid = 0;
        while (pending != 0) @(negedge i_clk);
        i_cfg_wdata = v;
        i_cfg_we = 1;
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed: zero length, extremes, every command, paused and unused
        write_step_cap(16'd1311);
        send_item(CMD_TICK, 16'd1000, 1'b0, 0, 0, 0, 0);
        send_item(CMD_KICK, 16'd0, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        send_item(CMD_TICK, 16'hFFFF, 1'b0, 0, 0, 0, 0);
        send_item(CMD_TICK, 16'hFFFF, 1'b0, 0, 0, 0, 0);
        send_item(CMD_TICK, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 0, 0, 0);
        send_item(CMD_UNUSED, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_KICK, 16'd0, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        send_item(CMD_TICK, 16'd0, 1'b0, 0, 0, 0, 0);
        send_item(CMD_TICK, 16'd700, 1'b0, 0, 0, 0, 0);
        send_item(CMD_KICK, 16'd0, 1'b0, 32'h0001_0000, 32'hFFFF_0000, 32'd327680000,
                  32'd655360);
        repeat (4) send_item(CMD_TICK, 16'd1311, 1'b0, 0, 0, 0, 0);
        send_item(CMD_RESET, 16'd0, 1'b0, 0, 0, 0, 0);
        send_item(CMD_TICK, 16'd500, 1'b0, 0, 0, 0, 0);
        send_item(CMD_KICK, 16'd0, 1'b0, 32'd1, 32'hFFFF_FFFF, 32'h0100_0000, 32'd1);
        repeat (3) send_item(CMD_TICK, 16'd2000, 1'b0, 0, 0, 0, 0);

        // random phases with different step caps, idling and receiver stalls
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  write_step_cap(16'hFFFF); end
                1: begin idle_pct = 59; stall_pct = 0;  write_step_cap(16'd0); end
                2: begin idle_pct = 0;  stall_pct = 59; write_step_cap(16'($urandom())); end
                3: begin idle_pct = 14; stall_pct = 14; write_step_cap(16'd1311); end
                default: begin idle_pct = 0; stall_pct = 0;
                    write_step_cap(16'($urandom_range(4000)));
                end
            endcase
            repeat (126) random_item();
        end
        s_tvalid = 0;

        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
